[hdl/vitr_pkg.sv]
// ----------------------------------------------------------------------------
// vitr_pkg
// Shared types, constants and helpers for the video interface timing block.
// ----------------------------------------------------------------------------
package vitr_pkg;

    localparam int unsigned REG_COUNT_DEF = 14;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned IDX_W  = ADDR_W - 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_VINTR = 2'd2
    } t_mode;

    localparam logic [IDX_W-1:0] IDX_STATUS        = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_WIDTH         = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_CURRENT       = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_VSYNC         = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_LAST_WRITABLE = IDX_W'(13);

    localparam int unsigned INTERLACE_POS = 6;

    localparam logic [DATA_W-1:0] LINE_DIVISOR     = 32'd1500;
    localparam logic [DATA_W-1:0] DEFAULT_DURATION = 32'd500000;
    localparam logic [DATA_W-1:0] FIRST_DURATION   = 32'd5000;

    // floor(x / 1500) = floor((x >> 2) / 375), by reciprocal ceil(2^39 / 375)
    localparam int unsigned   QUART_W    = DATA_W - 2;
    localparam int unsigned   RECIP_W    = 31;
    localparam int unsigned   RECIP_SH   = 39;
    localparam int unsigned   PROD_W     = QUART_W + RECIP_W;
    localparam int unsigned   LINE_W     = 22;
    localparam logic [RECIP_W-1:0] LINE_RECIP = 31'd1466015504;

    function automatic logic [LINE_W-1:0] div_line(input logic [DATA_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x[DATA_W-1:2]) * PROD_W'(LINE_RECIP);
        return prod[RECIP_SH +: LINE_W];
    endfunction

endpackage

[hdl/video_interface_timing_registers.sv]
// Each item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless stalled; register file, field bit, frame duration,
// next-interrupt count and interrupt flag all update in the cycle an item executes.
// Reset (i_rst_n low, synchronous): registers clear to zero, field bit and flag clear,
// frame duration and next-interrupt count load 5000, both pipeline stages empty.
// ----------------------------------------------------------------------------
// video_interface_timing_registers
// Video interface register file with current-line readback and frame timing.
// ----------------------------------------------------------------------------
module video_interface_timing_registers #(
    parameter int unsigned REG_COUNT = vitr_pkg::REG_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [vitr_pkg::MODE_W-1:0] i_mode,
    input  logic [vitr_pkg::ADDR_W-1:0] i_address,
    input  logic [vitr_pkg::DATA_W-1:0] i_write_data,
    input  logic [vitr_pkg::DATA_W-1:0] i_write_mask,
    input  logic [vitr_pkg::DATA_W-1:0] i_cpu_count,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [vitr_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_interrupt_pending,
    output logic                        o_status_changed,
    output logic                        o_width_changed,
    output logic                        o_schedule_valid,
    output logic [vitr_pkg::DATA_W-1:0] o_next_event_count
);
    import vitr_pkg::*;

    localparam int unsigned RIDX_W = $clog2(REG_COUNT);

    logic              r_in_valid;
    logic [MODE_W-1:0] r_mode;
    logic [ADDR_W-1:0] r_address;
    logic [DATA_W-1:0] r_write_data;
    logic [DATA_W-1:0] r_write_mask;
    logic [DATA_W-1:0] r_cpu_count;

    logic [DATA_W-1:0] r_regs [REG_COUNT];
    logic              r_field;
    logic [DATA_W-1:0] r_duration;
    logic [DATA_W-1:0] r_next_count;
    logic              r_flag;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic              r_status_chg;
    logic              r_width_chg;
    logic              r_sched;

    logic              w_advance;
    logic              w_exec;
    logic [IDX_W-1:0]  w_idx;
    logic [RIDX_W-1:0] w_ridx;
    logic              w_in_range;
    logic [DATA_W-1:0] w_cur_reg;
    logic [DATA_W-1:0] w_line_raw;
    logic [LINE_W-1:0] w_line;
    logic [DATA_W-1:0] w_cur_line;
    logic [DATA_W-1:0] w_vsync_p1;
    logic              w_diff;

    logic              n_field;
    logic [DATA_W-1:0] n_duration;
    logic [DATA_W-1:0] n_next_count;
    logic              n_flag;
    logic [DATA_W-1:0] n_read_data;
    logic              n_status_chg;
    logic              n_width_chg;
    logic              n_sched;
    logic              n_reg_we;
    logic [DATA_W-1:0] n_reg_wdata;
    logic              n_cur_we;

    assign w_advance = !r_out_valid || !i_stall;
    assign w_exec    = r_in_valid && w_advance;
    assign o_stall   = r_in_valid && !w_advance;

    assign w_idx      = r_address[ADDR_W-1:2];
    assign w_ridx     = r_address[RIDX_W+1:2];
    assign w_in_range = w_idx inside {[IDX_STATUS:IDX_LAST_WRITABLE]};
    assign w_cur_reg  = r_regs[w_ridx];

    assign w_line_raw = r_duration - (r_next_count - r_cpu_count);
    assign w_line     = div_line(w_line_raw);
    assign w_cur_line = {(DATA_W-LINE_W)'(0), w_line[LINE_W-1:1], r_field};
    assign w_vsync_p1 = r_regs[IDX_VSYNC[RIDX_W-1:0]] + DATA_W'(1);
    assign w_diff     = (w_cur_reg & r_write_mask) != (r_write_data & r_write_mask);

    always_comb begin
        n_field      = r_field;
        n_duration   = r_duration;
        n_next_count = r_next_count;
        n_flag       = r_flag;
        n_read_data  = '0;
        n_status_chg = 1'b0;
        n_width_chg  = 1'b0;
        n_sched      = 1'b0;
        n_reg_we     = 1'b0;
        n_reg_wdata  = (w_cur_reg & ~r_write_mask) | (r_write_data & r_write_mask);
        n_cur_we     = 1'b0;
        case (t_mode'(r_mode))
            MODE_READ: begin
                if (w_idx == IDX_CURRENT) begin
                    n_cur_we    = 1'b1;
                    n_read_data = w_cur_line;
                end else if (w_in_range) begin
                    n_read_data = w_cur_reg;
                end
            end
            MODE_WRITE: begin
                if (w_idx == IDX_CURRENT) begin
                    n_flag = 1'b0;
                end else if (w_in_range) begin
                    n_reg_we     = 1'b1;
                    n_status_chg = (w_idx == IDX_STATUS) && w_diff;
                    n_width_chg  = (w_idx == IDX_WIDTH) && w_diff;
                end
            end
            MODE_VINTR: begin
                n_field      = r_regs[IDX_STATUS[RIDX_W-1:0]][INTERLACE_POS] && !r_field;
                n_duration   = (w_vsync_p1 == DATA_W'(1)) ? DEFAULT_DURATION
                                                          : DATA_W'(w_vsync_p1 * LINE_DIVISOR);
                n_next_count = r_next_count + n_duration;
                n_flag       = 1'b1;
                n_sched      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_field      <= 1'b0;
            r_duration   <= FIRST_DURATION;
            r_next_count <= FIRST_DURATION;
            r_flag       <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_exec) begin
                r_field      <= n_field;
                r_duration   <= n_duration;
                r_next_count <= n_next_count;
                r_flag       <= n_flag;
                if (n_reg_we) begin
                    r_regs[w_ridx] <= n_reg_wdata;
                end
                if (n_cur_we) begin
                    r_regs[IDX_CURRENT[RIDX_W-1:0]] <= w_cur_line;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_mode       <= i_mode;
            r_address    <= i_address;
            r_write_data <= i_write_data;
            r_write_mask <= i_write_mask;
            r_cpu_count  <= i_cpu_count;
        end
        if (w_exec) begin
            r_read_data  <= n_read_data;
            r_status_chg <= n_status_chg;
            r_width_chg  <= n_width_chg;
            r_sched      <= n_sched;
        end
    end

    logic              r_pend;
    logic [DATA_W-1:0] r_evt_count;

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_pend      <= n_flag;
            r_evt_count <= n_next_count;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_interrupt_pending = r_pend;
    assign o_status_changed    = r_status_chg;
    assign o_width_changed     = r_width_chg;
    assign o_schedule_valid    = r_sched;
    assign o_next_event_count  = r_evt_count;

endmodule

[hdl/vitr_checker.sv]
// ----------------------------------------------------------------------------
// vitr_checker
// Port-level checks for the video interface timing block, bound to the top.
// ----------------------------------------------------------------------------
module vitr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [vitr_pkg::MODE_W-1:0] i_mode,
    input logic [vitr_pkg::ADDR_W-1:0] i_address,
    input logic [vitr_pkg::DATA_W-1:0] i_write_data,
    input logic [vitr_pkg::DATA_W-1:0] i_write_mask,
    input logic [vitr_pkg::DATA_W-1:0] i_cpu_count,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [vitr_pkg::DATA_W-1:0] o_read_data,
    input logic                        o_interrupt_pending,
    input logic                        o_status_changed,
    input logic                        o_width_changed,
    input logic                        o_schedule_valid,
    input logic [vitr_pkg::DATA_W-1:0] o_next_event_count
);
    import vitr_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data)
                               && $stable(o_next_event_count))
        else $error("result changed while stalled");

    a_sched_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_schedule_valid |-> o_interrupt_pending)
        else $error("scheduled event without pending interrupt");

    a_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status_changed || o_width_changed)
            |-> !o_schedule_valid && (o_read_data == '0))
        else $error("change flag on a non-write result");

    a_one_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status_changed |-> !o_width_changed)
        else $error("status and width changed by one transfer");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind video_interface_timing_registers vitr_checker u_vitr_checker (.*);

[sim/tb_video_interface_timing_registers.sv]
// ----------------------------------------------------------------------------
// tb_video_interface_timing_registers
// Self-checking bench for the video interface register block. A shadow copy of
// the register file, field bit, frame timing and interrupt flag predicts every
// result. Directed tests cover reset values, masked writes, frame events and one long
// receiver hold-off. A random phase with bursty input and random output stall follows.
// Each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_video_interface_timing_registers;
    timeunit 1ns;
    timeprecision 1ps;

    import vitr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam int unsigned       RANDOM_ITEMS = 1500;
    localparam int unsigned       HOLD_CYCLES  = 300;
    localparam int unsigned       REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pending;
        logic              status_chg;
        logic              width_chg;
        logic              sched;
        logic [DATA_W-1:0] next_count;
    } t_vi_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [MODE_W-1:0] i_mode;
    logic [ADDR_W-1:0] i_address;
    logic [DATA_W-1:0] i_write_data;
    logic [DATA_W-1:0] i_write_mask;
    logic [DATA_W-1:0] i_cpu_count;
    logic              o_valid;
    logic              i_stall;
    logic [DATA_W-1:0] o_read_data;
    logic              o_interrupt_pending;
    logic              o_status_changed;
    logic              o_width_changed;
    logic              o_schedule_valid;
    logic [DATA_W-1:0] o_next_event_count;

    logic [DATA_W-1:0] shadow_regs [0:15];
    logic              shadow_field;
    logic [DATA_W-1:0] shadow_duration;
    logic [DATA_W-1:0] shadow_next_count;
    logic              shadow_irq;

    t_vi_result pending_results [$];

    int fail_count    = 0;
    int checked_count = 0;
    int sent_count    = 0;
    int read_count    = 0;
    int write_count   = 0;
    int frame_count   = 0;
    int unused_count  = 0;
    int burst_left    = 0;
    int hold_ticket   = 0;
    int hold_served   = 0;
    int long_holds    = 0;

    video_interface_timing_registers u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_mode              (i_mode),
        .i_address           (i_address),
        .i_write_data        (i_write_data),
        .i_write_mask        (i_write_mask),
        .i_cpu_count         (i_cpu_count),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_read_data         (o_read_data),
        .o_interrupt_pending (o_interrupt_pending),
        .o_status_changed    (o_status_changed),
        .o_width_changed     (o_width_changed),
        .o_schedule_valid    (o_schedule_valid),
        .o_next_event_count  (o_next_event_count)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_vi_result predict_vi_result(
        input logic [MODE_W-1:0] mode,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] data,
        input logic [DATA_W-1:0] mask,
        input logic [DATA_W-1:0] cnt
    );
        t_vi_result        r;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] line;
        logic [DATA_W-1:0] vsync;
        logic              differs;
        r   = '0;
        idx = addr[ADDR_W-1:2];
        case (mode)
            MODE_READ: begin
                if (idx == IDX_CURRENT) begin
                    line = (shadow_duration - (shadow_next_count - cnt)) / LINE_DIVISOR;
                    shadow_regs[IDX_CURRENT] = {line[DATA_W-1:1], shadow_field};
                end
                if (idx < REG_COUNT_DEF)
                    r.read_data = shadow_regs[idx];
            end
            MODE_WRITE: begin
                if (idx == IDX_CURRENT) begin
                    shadow_irq = 1'b0;
                end else if (idx <= IDX_LAST_WRITABLE) begin
                    differs      = (shadow_regs[idx] & mask) != (data & mask);
                    r.status_chg = (idx == IDX_STATUS) && differs;
                    r.width_chg  = (idx == IDX_WIDTH) && differs;
                    shadow_regs[idx] = (shadow_regs[idx] & ~mask) | (data & mask);
                end
            end
            MODE_VINTR: begin
                vsync           = shadow_regs[IDX_VSYNC];
                shadow_field    = shadow_regs[IDX_STATUS][INTERLACE_POS] & ~shadow_field;
                shadow_duration = (vsync == '0) ? DEFAULT_DURATION
                                                : (vsync + 32'd1) * LINE_DIVISOR;
                shadow_next_count = shadow_next_count + shadow_duration;
                shadow_irq      = 1'b1;
                r.sched         = 1'b1;
            end
            default: begin
            end
        endcase
        r.irq_pending = shadow_irq;
        r.next_count  = shadow_next_count;
        return r;
    endfunction

    // hold payload until the transfer, then advance the burst / gap pattern
    task automatic send_item(
        input logic [MODE_W-1:0] mode,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] data,
        input logic [DATA_W-1:0] mask,
        input logic [DATA_W-1:0] cnt
    );
        int gap;
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_address    <= addr;
        i_write_data <= data;
        i_write_mask <= mask;
        i_cpu_count  <= cnt;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_results.push_back(predict_vi_result(mode, addr, data, mask, cnt));
        sent_count++;
        case (mode)
            MODE_READ:  read_count++;
            MODE_WRITE: write_count++;
            MODE_VINTR: frame_count++;
            default:    unused_count++;
        endcase
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_reset_values();
        send_item(MODE_READ, 16'h0000, '0, '0, '0);
        send_item(MODE_READ, 16'h0010, '0, '0, 32'h0000_0000);
        send_item(MODE_READ, 16'h0037, '1, '1, '1);
        send_item(MODE_READ, 16'h0038, '0, '0, '0);
        send_item(MODE_READ, 16'h003c, '0, '0, '0);
        send_item(MODE_READ, 16'hffff, '0, '0, '0);
    endtask

    task automatic test_masked_writes();
        send_item(MODE_WRITE, 16'h0000, '1, '1, '0);
        send_item(MODE_WRITE, 16'h0001, '1, '1, '0);
        send_item(MODE_WRITE, 16'h0008, 32'h0000_1234, 32'h0000_ff00, '0);
        send_item(MODE_WRITE, 16'h000a, '1, '0, '0);
        send_item(MODE_WRITE, 16'h0034, '1, '1, '0);
        send_item(MODE_WRITE, 16'h0010, '1, '1, '1);
        send_item(MODE_WRITE, 16'h0038, '1, '1, '0);
        send_item(MODE_WRITE, 16'hfffc, '1, '1, '0);
        send_item(MODE_READ,  16'h0008, '0, '0, '0);
        send_item(MODE_READ,  16'h0034, '0, '0, '0);
    endtask

    task automatic test_vertical_interrupt();
        send_item(MODE_VINTR,  16'h0000, '0, '0, '0);
        send_item(MODE_READ,   16'h0010, '0, '0, '1);
        send_item(MODE_WRITE,  16'h0018, '1, '1, '0);
        send_item(MODE_VINTR,  16'h0000, '0, '0, '0);
        send_item(MODE_WRITE,  16'h0018, 32'd524, '1, '0);
        send_item(MODE_VINTR,  16'h0000, '0, '0, '0);
        send_item(MODE_UNUSED, 16'h0000, '1, '1, '1);
        send_item(MODE_WRITE,  16'h0010, '0, '0, '0);
        send_item(MODE_READ,   16'h0010, '0, '0, '0);
    endtask

    task automatic test_backpressure();
        hold_ticket <= hold_ticket + 1;
        burst_left = 80;
        repeat (60)
            send_item(MODE_READ, {12'h000, 4'($urandom_range(0, 15))}, $urandom, $urandom,
                      $urandom);
    endtask

    task automatic test_random_traffic();
        int                unsigned pick;
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] cnt;
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            mode = (pick < 40) ? MODE_READ : (pick < 80) ? MODE_WRITE :
                   (pick < 94) ? MODE_VINTR : MODE_UNUSED;
            if ($urandom_range(0, 6) == 0)
                addr = 16'($urandom);
            else
                addr = {10'd0, 4'($urandom_range(0, 15)), 2'($urandom)};
            if (mode == MODE_READ && $urandom_range(0, 2) == 0)
                addr = {10'd0, 4'(IDX_CURRENT), 2'($urandom)};
            data = $urandom;
            if (addr[ADDR_W-1:2] == IDX_VSYNC && $urandom_range(0, 1) == 0)
                data = $urandom_range(0, 600);
            case ($urandom_range(0, 5))
                0:       mask = '1;
                1:       mask = '0;
                2:       mask = 32'd1 << $urandom_range(0, 31);
                default: mask = $urandom;
            endcase
            if ($urandom_range(0, 1) == 0)
                cnt = shadow_next_count - $urandom_range(0, 600000);
            else
                cnt = $urandom;
            send_item(mode, addr, data, mask, cnt);
        end
    endtask

    initial begin : rx_side
        int style;
        int style_left;
        int hold_left;
        int phase;
        style      = 0;
        style_left = 0;
        hold_left  = 0;
        phase      = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                hold_left   = HOLD_CYCLES;
                long_holds++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(40, 300);
                end
                style_left--;
                phase++;
                case (style)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 9) < 6);
                    default: i_stall <= ((phase % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_vi_result want;
        t_vi_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.read_data   = o_read_data;
            got.irq_pending = o_interrupt_pending;
            got.status_chg  = o_status_changed;
            got.width_chg   = o_width_changed;
            got.sched       = o_schedule_valid;
            got.next_count  = o_next_event_count;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: rd=%h irq=%b st=%b wd=%b sch=%b nxt=%h",
                             $realtime, got.read_data, got.irq_pending, got.status_chg,
                             got.width_chg, got.sched, got.next_count);
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("[%0t] mismatch on result %0d", $realtime, checked_count);
                        $display("  exp rd=%h irq=%b st=%b wd=%b sch=%b nxt=%h",
                                 want.read_data, want.irq_pending, want.status_chg,
                                 want.width_chg, want.sched, want.next_count);
                        $display("  got rd=%h irq=%b st=%b wd=%b sch=%b nxt=%h",
                                 got.read_data, got.irq_pending, got.status_chg,
                                 got.width_chg, got.sched, got.next_count);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #(12ns * 400000);
        $display("FAIL video_interface_timing_registers");
        $finish;
    end

    initial begin : main_seq
        int i;
        for (i = 0; i < 16; i++)
            shadow_regs[i] = '0;
        shadow_field      = 1'b0;
        shadow_duration   = FIRST_DURATION;
        shadow_next_count = FIRST_DURATION;
        shadow_irq        = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_mode       <= MODE_READ;
        i_address    <= '0;
        i_write_data <= '0;
        i_write_mask <= '0;
        i_cpu_count  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_masked_writes();
        test_vertical_interrupt();
        test_backpressure();
        test_random_traffic();

        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d transfers: %0d reads, %0d writes, %0d frame events, %0d unused",
                 sent_count, read_count, write_count, frame_count, unused_count);
        $display("%0d results checked, %0d long receiver holds, %0d failures",
                 checked_count, long_holds, fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("PASS video_interface_timing_registers");
        end else begin
            $display("FAIL video_interface_timing_registers");
        end
        $finish;
    end

endmodule
